// ===== sv/tanhshrink_activation_assert.svh =====
// Assertion macros used by the tanhshrink top level.
`ifndef TANHSHRINK_ACTIVATION_ASSERT_SVH
`define TANHSHRINK_ACTIVATION_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define TSA_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define TSA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tanhs_pkg.sv =====
// Shared types and constants for the tanhshrink pipeline.
`timescale 1ns / 1ps

package tanhs_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 12;

	// exp(-2a) datapath, Q1.30
	localparam int Q_FRAC = 30;
	localparam int W_BITS = 27;   // 2a/256 in Q30, a < 16
	localparam int T_BITS = 31;   // holds 1.0 in Q30
	localparam logic [T_BITS-1:0] Q30_ONE = T_BITS'(1) << Q_FRAC;

	// exact floor division of a W_BITS value by 3 and by 5
	localparam int RCP_BITS = 28;
	localparam logic [RCP_BITS-1:0] RCP3 = 28'd178956971;
	localparam int RCP3_SHIFT = 29;
	localparam logic [RCP_BITS-1:0] RCP5 = 28'd214748365;
	localparam int RCP5_SHIFT = 30;

	typedef struct packed {
		logic valid;
		logic last;
		logic neg;
		logic big;
	} side_t;

endpackage

// ===== sv/tanhs_in_if.sv =====
// Input sample channel.
`timescale 1ns / 1ps

interface tanhs_in_if #(parameter int DATA_WIDTH = tanhs_pkg::DATA_WIDTH_DEF);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] sample_in;
	logic end_of_vector;

	modport source (output valid, sample_in, end_of_vector, input ready);
	modport sink (input valid, sample_in, end_of_vector, output ready);
endinterface

// ===== sv/tanhs_out_if.sv =====
// Result sample channel.
`timescale 1ns / 1ps

interface tanhs_out_if #(parameter int DATA_WIDTH = tanhs_pkg::DATA_WIDTH_DEF);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] sample_out;
	logic end_of_vector_out;

	modport source (output valid, sample_out, end_of_vector_out, input ready);
	modport sink (input valid, sample_out, end_of_vector_out, output ready);
endinterface

// ===== sv/tanhs_exp.sv =====
// exp(-2a) pipeline: Taylor series in Horner form, then eight squarings.
`timescale 1ns / 1ps

module tanhs_exp #(
	parameter int DATA_WIDTH = tanhs_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  tanhs_pkg::side_t              side_in,
	input  logic [DATA_WIDTH-1:0]         mag_in,
	input  logic [tanhs_pkg::W_BITS-1:0]  w_in,
	output tanhs_pkg::side_t              side_out,
	output logic [DATA_WIDTH-1:0]         mag_out,
	output logic [tanhs_pkg::T_BITS-1:0]  e_out
);

	localparam int WB = tanhs_pkg::W_BITS;
	localparam int TB = tanhs_pkg::T_BITS;
	localparam int QF = tanhs_pkg::Q_FRAC;
	localparam int PB = WB + tanhs_pkg::RCP_BITS;
	localparam int PW = WB + TB;
	localparam int SB = 2 * TB;
	localparam int NS = 14;
	localparam int SQ_FIRST = 7;
	localparam int W_LAST = 5;
	localparam logic [TB-1:0] ONE = tanhs_pkg::Q30_ONE;

	tanhs_pkg::side_t      side_s [1:NS];
	logic [DATA_WIDTH-1:0] mag_s  [1:NS];
	logic [WB-1:0]         w_s    [1:W_LAST];
	logic [WB-1:0]         d5_s1;
	logic [PW-1:0]         p4_s2;
	logic [PW-1:0]         p3_s3;
	logic [WB-1:0]         d3_s4;
	logic [PW-1:0]         p2_s5;
	logic [PW-1:0]         p1_s6;
	logic [TB-1:0]         sq_s   [SQ_FIRST:NS];

	logic [PB-1:0] prod5;
	logic [PB-1:0] prod3;
	logic [WB-1:0] q3;
	logic [TB-1:0] t5;
	logic [TB-1:0] t4;
	logic [TB-1:0] t3;
	logic [TB-1:0] t2;
	logic [TB-1:0] t1;
	logic [SB-1:0] sq_prod [SQ_FIRST:NS];

	// first Horner step has t = 1, so the product is w itself
	always_comb begin
		prod5 = PB'(w_in) * PB'(tanhs_pkg::RCP5);
		t5    = ONE - TB'(d5_s1);
		t4    = ONE - TB'(p4_s2 >> (QF + 2));
		q3    = WB'(p3_s3 >> QF);
		prod3 = PB'(q3) * PB'(tanhs_pkg::RCP3);
		t3    = ONE - TB'(d3_s4);
		t2    = ONE - TB'(p2_s5 >> (QF + 1));
		t1    = ONE - TB'(p1_s6 >> QF);
		sq_prod[SQ_FIRST] = SB'(t1) * SB'(t1);
		for (int i = SQ_FIRST + 1; i <= NS; i++) begin
			sq_prod[i] = SB'(sq_s[i-1]) * SB'(sq_s[i-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NS; i++) begin
				side_s[i] <= '0;
			end
		end else if (en) begin
			side_s[1] <= side_in;
			for (int i = 2; i <= NS; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s[1] <= mag_in;
			for (int i = 2; i <= NS; i++) begin
				mag_s[i] <= mag_s[i-1];
			end
			w_s[1] <= w_in;
			for (int i = 2; i <= W_LAST; i++) begin
				w_s[i] <= w_s[i-1];
			end
			d5_s1 <= WB'(prod5 >> tanhs_pkg::RCP5_SHIFT);
			p4_s2 <= PW'(w_s[1]) * PW'(t5);
			p3_s3 <= PW'(w_s[2]) * PW'(t4);
			d3_s4 <= WB'(prod3 >> tanhs_pkg::RCP3_SHIFT);
			p2_s5 <= PW'(w_s[4]) * PW'(t3);
			p1_s6 <= PW'(w_s[5]) * PW'(t2);
			for (int i = SQ_FIRST; i <= NS; i++) begin
				sq_s[i] <= TB'(sq_prod[i] >> QF);
			end
		end
	end

	assign side_out = side_s[NS];
	assign mag_out  = mag_s[NS];
	assign e_out    = sq_s[NS];

endmodule

// ===== sv/tanhs_div.sv =====
// tanh = (1 - e) / (1 + e), rounded half up: restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module tanhs_div #(
	parameter int DATA_WIDTH = tanhs_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = tanhs_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  tanhs_pkg::side_t              side_in,
	input  logic [DATA_WIDTH-1:0]         mag_in,
	input  logic [tanhs_pkg::T_BITS-1:0]  e_in,
	output tanhs_pkg::side_t              side_out,
	output logic [DATA_WIDTH-1:0]         mag_out,
	output logic [FRAC_BITS:0]            q_out
);

	localparam int QB = FRAC_BITS + 1;
	localparam int NS = QB + 1;
	localparam int DB = tanhs_pkg::T_BITS + 2;
	localparam int RW = FRAC_BITS + DB;
	localparam logic [tanhs_pkg::T_BITS-1:0] ONE = tanhs_pkg::Q30_ONE;

	tanhs_pkg::side_t      side_s [1:NS];
	logic [DATA_WIDTH-1:0] mag_s  [1:NS];
	logic [RW-1:0]         r_s    [1:QB];
	logic [DB-1:0]         d_s    [1:QB];
	logic [QB-1:0]         q_s    [1:NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NS; i++) begin
				side_s[i] <= '0;
			end
		end else if (en) begin
			side_s[1] <= side_in;
			for (int i = 2; i <= NS; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// setup: dividend 2*num*2^FRAC_BITS + den, divisor 2*den
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s[1] <= mag_in;
			for (int i = 2; i <= NS; i++) begin
				mag_s[i] <= mag_s[i-1];
			end
			r_s[1] <= (RW'(ONE - e_in) << (FRAC_BITS + 1)) + RW'(ONE) + RW'(e_in);
			d_s[1] <= (DB'(ONE) + DB'(e_in)) << 1;
			q_s[1] <= '0;
		end
	end

	for (genvar k = 2; k <= NS; k++) begin : g_step
		localparam int BIT = NS - k;
		logic [RW:0] diff;
		logic        take;

		assign diff = {1'b0, r_s[k-1]} - {1'b0, (RW'(d_s[k-1]) << BIT)};
		assign take = !diff[RW];

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k] <= q_s[k-1] | (take ? (QB'(1) << BIT) : QB'(0));
			end
		end

		if (k <= QB) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					r_s[k] <= take ? diff[RW-1:0] : r_s[k-1];
					d_s[k] <= d_s[k-1];
				end
			end
		end
	end

	assign side_out = side_s[NS];
	assign mag_out  = mag_s[NS];
	assign q_out    = q_s[NS];

endmodule

// ===== sv/tanhshrink_activation.sv =====
// Tanhshrink activation, y = x - tanh(x), signed fixed point, fully pipelined.
//
// channel  | role | payload                                  | handshake
// operand  | sink | sample_in[DATA_WIDTH], end_of_vector     | valid / ready
// result   | src  | sample_out[DATA_WIDTH], end_of_vector_out | valid / ready
//
// One request per cycle, sustained while no result waits untaken. The pipeline has
// one entry stage, 14 for exp(-2|x|) (one multiplier per stage), FRAC_BITS + 2 in the
// restoring divider (one quotient bit per stage), and two finishing stages.
// Reset clears only the side flags (valid, last, neg, big). While a result waits untaken, every stage holds
// and operand.ready is low.
`timescale 1ns / 1ps
`include "tanhshrink_activation_assert.svh"

module tanhshrink_activation #(
	parameter int DATA_WIDTH = tanhs_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = tanhs_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	tanhs_in_if.sink  operand,
	tanhs_out_if.source result
);

	localparam int WB = tanhs_pkg::W_BITS;
	localparam int TB = tanhs_pkg::T_BITS;
	localparam int QB = FRAC_BITS + 1;
	localparam int AW = FRAC_BITS + 4;
	localparam int VW = WB + 8;
	localparam int CW = (DATA_WIDTH > FRAC_BITS + 5) ? DATA_WIDTH : FRAC_BITS + 5;
	localparam logic [CW-1:0] BIG_LIM = CW'(16) << FRAC_BITS;
	localparam logic [CW-1:0] TH_ONE  = CW'(1) << FRAC_BITS;

	logic en;

	// entry stage
	logic [DATA_WIDTH-1:0] raw;
	logic                  neg_c;
	logic [DATA_WIDTH-1:0] mag_c;
	logic [VW-1:0]         v_c;
	tanhs_pkg::side_t      side_c;

	tanhs_pkg::side_t      side_s1;
	logic [DATA_WIDTH-1:0] mag_s1;
	logic [WB-1:0]         w_s1;

	tanhs_pkg::side_t      exp_side;
	logic [DATA_WIDTH-1:0] exp_mag;
	logic [TB-1:0]         exp_e;

	tanhs_pkg::side_t      div_side;
	logic [DATA_WIDTH-1:0] div_mag;
	logic [QB-1:0]         div_q;

	// stage numbers below are for the default FRAC_BITS
	logic [CW-1:0]         th_c;
	tanhs_pkg::side_t      side_s30;
	logic [DATA_WIDTH-1:0] mag_s30;
	logic [DATA_WIDTH-1:0] th_s30;
	tanhs_pkg::side_t      side_s31;
	logic [DATA_WIDTH-1:0] y_s31;

	assign en = result.ready || !side_s31.valid;
	assign operand.ready = en;

	always_comb begin
		raw   = operand.sample_in;
		neg_c = raw[DATA_WIDTH-1];
		mag_c = neg_c ? DATA_WIDTH'(~raw + DATA_WIDTH'(1)) : raw;
		// 2|x| in Q30, divided by 256 into w_s1; only the low bits matter below the saturation limit
		v_c   = VW'(AW'(mag_c)) << (tanhs_pkg::Q_FRAC + 1 - FRAC_BITS);
		side_c.valid = operand.valid;
		side_c.last  = operand.end_of_vector;
		side_c.neg   = neg_c;
		side_c.big   = CW'(mag_c) >= BIG_LIM;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1  <= '0;
			side_s30 <= '0;
			side_s31 <= '0;
		end else if (en) begin
			side_s1  <= side_c;
			side_s30 <= div_side;
			side_s31 <= side_s30;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_c;
			w_s1   <= v_c[VW-1:8];
		end
	end

	tanhs_exp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.side_in  (side_s1),
		.mag_in   (mag_s1),
		.w_in     (w_s1),
		.side_out (exp_side),
		.mag_out  (exp_mag),
		.e_out    (exp_e)
	);

	tanhs_div #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.side_in  (exp_side),
		.mag_in   (exp_mag),
		.e_in     (exp_e),
		.side_out (div_side),
		.mag_out  (div_mag),
		.q_out    (div_q)
	);

	// saturate for large |x|, never let tanh exceed |x|
	always_comb begin
		th_c = (CW'(div_q) > CW'(div_mag)) ? CW'(div_mag) : CW'(div_q);
		if (div_side.big) begin
			th_c = TH_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s30 <= div_mag;
			th_s30  <= DATA_WIDTH'(th_c);
			y_s31   <= side_s30.neg ? (th_s30 - mag_s30) : (mag_s30 - th_s30);
		end
	end

	assign result.valid             = side_s31.valid;
	assign result.sample_out        = y_s31;
	assign result.end_of_vector_out = side_s31.last;

	`TSA_ASSERT_NEXT(a_entry, operand.valid && operand.ready, side_s1.valid, "accepted request lost at entry")
	`TSA_ASSERT_NOW(a_exp_range, exp_side.valid, exp_e <= tanhs_pkg::Q30_ONE, "exp above one")
	`TSA_ASSERT_NOW(a_div_range, div_side.valid, div_q <= (QB'(1) << FRAC_BITS), "tanh above one")
	`TSA_ASSERT_NOW(a_th_clamp, side_s30.valid, th_s30 <= mag_s30, "tanh exceeds magnitude")
	`TSA_ASSERT_NOW(a_sign, result.valid && (result.sample_out != '0), result.sample_out[DATA_WIDTH-1] == side_s31.neg, "result sign differs from input")

endmodule
